// ----- hw/rtl/tccc_pkg.sv -----
// ----------------------------------------------------------------------------
// tccc_pkg
// Shared codes, constants and the result word type of the cursor controller.
// ----------------------------------------------------------------------------
package tccc_pkg;

  // request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // command codes
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_DRAW   = 2'd1;
  localparam logic [1:0] CMD_SCROLL = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // control characters
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  localparam logic [7:0] FIRST_PRINT = 8'd32;
  localparam logic [7:0] END_PRINT   = 8'd127;
  localparam logic [8:0] TAB_MASK    = 9'h1F8;

  // configuration register indexes
  localparam logic CFG_COLUMNS   = 1'b0;
  localparam logic CFG_TEXT_ROWS = 1'b1;

  localparam logic [7:0] COLUMNS_RESET   = 8'd80;
  localparam logic [7:0] TEXT_ROWS_RESET = 8'd25;

  // One queued word: the first result of an item, plus a flag that a
  // scroll result follows it. Cursor fields are shared by both results.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] glyph;
    logic [7:0] draw_col;
    logic [7:0] draw_row;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic       two;
  } res_t;

endpackage

// ----- hw/rtl/text_console_cursor_control.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_control
// Text console cursor controller: takes put-character, set-cursor and clear
// requests, tracks the cursor and emits draw, scroll and clear commands.
// ----------------------------------------------------------------------------
//
//  channel  handshake          payload
//  -------  -----------------  ---------------------------------------------
//  in       in_valid/in_ready  req_type, char_code, new_col, new_row
//  out      out_valid/out_rdy  command, glyph, draw_col, draw_row,
//                              cursor_col_out, cursor_row_out, last
//  cfg      cfg_we             cfg_index (0 columns, 1 text_rows), cfg_wdata
//
//  One request is taken per cycle while in_ready is high; its words are
//  registered in the result register, or in the skid stage when that is busy.
//  A request that draws and then scrolls yields two words on the output side;
//  the result register plus skid stage absorb the extra word. in_ready drops only when the skid stage holds a word.
//  rst_n is synchronous: sizes go to 80 x 25, cursor to the home cell.
//  A size write also sends the cursor home.
//
module text_console_cursor_control import tccc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_new_col,
  input  logic [7:0] in_new_row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_command,
  output logic [7:0] out_glyph,
  output logic [7:0] out_draw_col,
  output logic [7:0] out_draw_row,
  output logic [7:0] out_cursor_col_out,
  output logic [7:0] out_cursor_row_out,
  output logic       out_last
);

  res_t res;
  logic push;

  // advance the cursor on the same edge the word is queued
  assign push = in_valid && in_ready;

  tccc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .req_type  (in_req_type),
    .char_code (in_char_code),
    .new_col   (in_new_col),
    .new_row   (in_new_row),
    .res       (res)
  );

  // hold results until taken; split draw-then-scroll into two words
  tccc_outq u_outq (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .res                (res),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command        (out_command),
    .out_glyph          (out_glyph),
    .out_draw_col       (out_draw_col),
    .out_draw_row       (out_draw_row),
    .out_cursor_col_out (out_cursor_col_out),
    .out_cursor_row_out (out_cursor_row_out),
    .out_last           (out_last)
  );

  // a full skid stage means a word is waiting at the output
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending output word");

  // the word after a non-final one is the final scroll of the same item
  a_second_is_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_last && out_command == CMD_SCROLL)
    else $error("second word of an item is not a final scroll");

  // only draw words carry glyph and cell
  a_nondraw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command != CMD_DRAW |->
      out_glyph == 8'd0 && out_draw_col == 8'd0 && out_draw_row == 8'd0)
    else $error("non-draw word carries glyph or cell");

  // a non-final word is always the draw of a draw-then-scroll pair
  a_draw_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_command == CMD_DRAW)
    else $error("non-final word is not a draw");

endmodule

// ----- hw/rtl/tccc_core.sv -----
// ----------------------------------------------------------------------------
// tccc_core
// Size registers, cursor registers and the single-pass request decode.
// ----------------------------------------------------------------------------
module tccc_core import tccc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       push,
  input  logic [1:0] req_type,
  input  logic [7:0] char_code,
  input  logic [7:0] new_col,
  input  logic [7:0] new_row,
  output res_t       res
);

  logic [7:0] columns_r, columns_nxt;
  logic [7:0] text_rows_r, text_rows_nxt;
  logic [7:0] cur_col_r, cur_col_nxt;
  logic [7:0] cur_row_r, cur_row_nxt;

  logic [7:0] cols, rows;
  logic [7:0] col, row;
  logic [8:0] tab;
  logic [1:0] cmd;
  logic [7:0] glyph, dcol, drow;
  logic       two;

  always_comb begin
    cols = (columns_r == 8'd0) ? 8'd1 : columns_r;
    rows = (text_rows_r == 8'd0) ? 8'd1 : text_rows_r;
    col  = (cur_col_r >= cols) ? cols - 8'd1 : cur_col_r;
    row  = (cur_row_r >= rows) ? rows - 8'd1 : cur_row_r;
    tab  = ({1'b0, col} + 9'd8) & TAB_MASK;
    cmd   = CMD_NONE;
    glyph = 8'd0;
    dcol  = 8'd0;
    drow  = 8'd0;
    two   = 1'b0;
    unique case (req_type)
      REQ_PUT: begin
        unique case (char_code)
          CH_LF: begin
            col = 8'd0;
            row = row + 8'd1;
          end
          CH_CR: col = 8'd0;
          CH_TAB: begin
            if (tab >= {1'b0, cols}) begin
              col = 8'd0;
              row = row + 8'd1;
            end else begin
              col = tab[7:0];
            end
          end
          CH_BS: begin
            if (col != 8'd0) begin
              col = col - 8'd1;
            end else if (row != 8'd0) begin
              row = row - 8'd1;
              col = cols - 8'd1;
            end
            cmd   = CMD_DRAW;
            glyph = FIRST_PRINT;
            dcol  = col;
            drow  = row;
          end
          default: begin
            if (char_code >= FIRST_PRINT && char_code < END_PRINT) begin
              cmd   = CMD_DRAW;
              glyph = char_code;
              dcol  = col;
              drow  = row;
              if (col + 8'd1 >= cols) begin
                col = 8'd0;
                row = row + 8'd1;
              end else begin
                col = col + 8'd1;
              end
            end
          end
        endcase
        // past the last row: scroll, after the draw if there is one
        if (row >= rows) begin
          if (cmd == CMD_NONE) begin
            cmd = CMD_SCROLL;
          end else begin
            two = 1'b1;
          end
          row = rows - 8'd1;
        end
      end
      REQ_SET: begin
        if (new_col < cols) col = new_col;
        if (new_row < rows) row = new_row;
      end
      REQ_CLEAR: begin
        cmd = CMD_CLEAR;
        col = 8'd0;
        row = 8'd0;
      end
      default: ;
    endcase
  end

  assign res = '{command: cmd, glyph: glyph, draw_col: dcol, draw_row: drow,
                 cursor_col: col, cursor_row: row, two: two};

  always_comb begin
    columns_nxt   = columns_r;
    text_rows_nxt = text_rows_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    if (cfg_we) begin
      if (cfg_index == CFG_COLUMNS) begin
        columns_nxt = cfg_wdata;
      end else begin
        text_rows_nxt = cfg_wdata;
      end
      cur_col_nxt = 8'd0;
      cur_row_nxt = 8'd0;
    end else if (push) begin
      cur_col_nxt = col;
      cur_row_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r   <= COLUMNS_RESET;
      text_rows_r <= TEXT_ROWS_RESET;
      cur_col_r   <= 8'd0;
      cur_row_r   <= 8'd0;
    end else begin
      columns_r   <= columns_nxt;
      text_rows_r <= text_rows_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
    end
  end

endmodule

// ----- hw/rtl/tccc_outq.sv -----
// ----------------------------------------------------------------------------
// tccc_outq
// Result register with skid stage; splits a two-result word into two beats.
// ----------------------------------------------------------------------------
module tccc_outq import tccc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  res_t       res,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_command,
  output logic [7:0] out_glyph,
  output logic [7:0] out_draw_col,
  output logic [7:0] out_draw_row,
  output logic [7:0] out_cursor_col_out,
  output logic [7:0] out_cursor_row_out,
  output logic       out_last
);

  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic phase_r, phase_nxt;
  logic fire, pop;

  assign in_ready  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign fire      = main_valid_r && out_ready;
  assign pop       = fire && out_last;

  // second beat of a two-result word is always a bare scroll
  always_comb begin
    out_cursor_col_out = main_r.cursor_col;
    out_cursor_row_out = main_r.cursor_row;
    if (main_r.two && phase_r) begin
      out_command  = CMD_SCROLL;
      out_glyph    = 8'd0;
      out_draw_col = 8'd0;
      out_draw_row = 8'd0;
      out_last     = 1'b1;
    end else begin
      out_command  = main_r.command;
      out_glyph    = main_r.glyph;
      out_draw_col = main_r.draw_col;
      out_draw_row = main_r.draw_row;
      out_last     = !main_r.two;
    end
  end

  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    phase_nxt      = phase_r;
    if (fire) begin
      phase_nxt = !out_last;
    end
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
      phase_r      <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      phase_r      <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
